[rtl/prime_sum_sieve_defines.svh]
// ----------------------------------------------------------------------------
// Prime sum sieve assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PRIME_SUM_SIEVE_DEFINES_SVH
`define PRIME_SUM_SIEVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/psum_pkg.sv]
// ----------------------------------------------------------------------------
// Prime sum sieve package
// Field widths, the total ceiling and the sequencer state type.
// ----------------------------------------------------------------------------
package psum_pkg;

    localparam int LIMIT_W = 12;
    localparam int TOTAL_W = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_START,
        ST_CHECK,
        ST_STRIKE,
        ST_FIN
    } psum_state_t;

endpackage

[rtl/psum_ram.sv]
// ----------------------------------------------------------------------------
// Prime sum sieve RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psum_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/prime_sum_sieve.sv]
// ----------------------------------------------------------------------------
// Prime sum sieve
// Sums all primes up to an inclusive limit with a sieve of Eratosthenes.
// ----------------------------------------------------------------------------
// Usage:
// One beat on the s_ channel carries a limit n; the block answers with one
// beat on the m_ channel holding the sum of all primes <= n. A limit above
// MAX_LIMIT is clamped to it, and a limit below two gives zero.
// Items are worked one at a time. After a beat is taken the block marks
// entries 0..n of a one-bit sieve RAM, then walks p = 2..n, reading each
// entry; each prime found is added to the total and strikes its multiples
// from p*p up to n before the walk moves on. For a small limit the
// sequencer goes straight to the finish step and skips the sieve.
// The result waits in an output register; s_ready rises again as soon as
// the walk has handed over its total, so a new limit may be taken while the
// receiver stalls. A finished walk holds until the output register is free.
// Reset clears the sequencer and the output valid; the RAM needs no
// clearing because each item writes every entry it later reads.
// ----------------------------------------------------------------------------
module prime_sum_sieve
    import psum_pkg::*;
#(
    parameter int MAX_LIMIT = 4095
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LIMIT_W-1:0] s_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TOTAL_W-1:0] m_prime_total
);

`include "prime_sum_sieve_defines.svh"

    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = 2 * AW;

    psum_state_t state_reg, state_next;
    logic [AW-1:0]      n_reg, n_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [MW-1:0]      m_reg, m_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    logic [31:0]        limit_ext;
    logic [AW-1:0]      n_clamp;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;

    psum_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_sieve_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign limit_ext = 32'(s_limit);
    assign n_clamp   = AW'((limit_ext > 32'(MAX_LIMIT)) ? 32'(MAX_LIMIT) : limit_ext);
    assign sum_wide  = {1'b0, total_reg} + (TOTAL_W + 1)'(p_reg);
    assign sum_sat   = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        p_reg         <= p_next;
        m_reg         <= m_next;
        out_total_reg <= out_total_next;
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        total_next     = total_reg;
        out_total_next = out_total_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = 1'b1;
        ram_raddr      = p_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    n_next     = n_clamp;
                    k_next     = '0;
                    total_next = '0;
                    state_next = (n_clamp < AW'(2)) ? ST_FIN : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (k_reg == n_reg) begin
                    state_next = ST_START;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end
            ST_START: begin
                // Separate cycle so the first read never meets the last mark.
                p_next     = AW'(2);
                ram_raddr  = AW'(2);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (ram_rdata) begin
                    total_next = sum_sat;
                    m_next     = MW'(p_reg) * MW'(p_reg);
                    state_next = (p_reg == n_reg) ? ST_FIN : ST_STRIKE;
                end else if (p_reg == n_reg) begin
                    state_next = ST_FIN;
                end else begin
                    p_next    = p_reg + AW'(1);
                    ram_raddr = p_reg + AW'(1);
                end
            end
            ST_STRIKE: begin
                if (m_reg <= MW'(n_reg)) begin
                    ram_we    = 1'b1;
                    ram_waddr = m_reg[AW-1:0];
                    ram_wdata = 1'b0;
                    m_next    = m_reg + MW'(p_reg);
                end else begin
                    // All strikes land above p+1, so this read sees settled data.
                    p_next     = p_reg + AW'(1);
                    ram_raddr  = p_reg + AW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_total_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_total = out_total_reg;

    `PSS_ASSERT_IMPL(a_write_in_range, ram_we, ram_waddr <= n_reg,
        "sieve write beyond the current limit")
    `PSS_ASSERT_IMPL(a_check_in_range, state_reg == ST_CHECK,
        (p_reg >= AW'(2)) && (p_reg <= n_reg), "checked number outside 2..n")
    `PSS_ASSERT_NEXT(a_result_from_fin, !m_valid && state_reg != ST_FIN, !m_valid,
        "result beat raised outside the finish step")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Prime sum sieve testbench
// Feeds limits through the s_ channel and checks every m_ channel beat
// against a sieve computed in the bench. Directed corner limits come first,
// then three random phases with changing idle patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import psum_pkg::*;
();

    localparam int SIEVE_MAX       = 4095;
    localparam int WATCHDOG_LIMIT  = 200000;
    localparam int HOLD_AT_RESULT  = 85;
    localparam int HOLD_CYCLES     = 40000;
    localparam int SETTLE_CYCLES   = 64;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [LIMIT_W-1:0] s_limit       = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [TOTAL_W-1:0] m_prime_total;

    logic [LIMIT_W-1:0] pending_limits[$];
    logic [TOTAL_W-1:0] expected_totals[$];

    int send_idle_pct = 11;
    int recv_idle_pct = 47;
    int error_count   = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int stall_cycles  = 0;

    prime_sum_sieve #(
        .MAX_LIMIT(SIEVE_MAX)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_limit      (s_limit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_total(m_prime_total)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Sum of all primes up to n, saturating at the output width.
    function automatic logic [TOTAL_W-1:0] prime_sum_upto(input logic [LIMIT_W-1:0] lim);
        bit          struck[0:SIEVE_MAX];
        int unsigned n;
        int unsigned sum;
        int unsigned m;
        n   = 32'(lim);
        sum = 0;
        if (n > SIEVE_MAX) begin
            n = SIEVE_MAX;
        end
        if (n < 2) begin
            return '0;
        end
        for (int unsigned k = 0; k <= n; k++) begin
            struck[k] = 1'b0;
        end
        for (int unsigned p = 2; p <= n; p++) begin
            if (!struck[p]) begin
                sum = sum + p;
                if (sum > 32'(TOTAL_MAX)) begin
                    sum = 32'(TOTAL_MAX);
                end
                for (m = p * p; m <= n; m += p) begin
                    struck[m] = 1'b1;
                end
            end
        end
        return sum[TOTAL_W-1:0];
    endfunction

    // Sender: takes the next limit from the pending queue when the slot is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_totals.push_back(prime_sum_upto(s_limit));
            end
            if (!s_valid || s_ready) begin
                if (pending_limits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_limit <= pending_limits.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and applies back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_totals.size() == 0) begin
                    $error("prime_total beat with no expectation: actual %0d", m_prime_total);
                    error_count++;
                end else if (m_prime_total !== expected_totals[0]) begin
                    $error("prime_total mismatch: expected %0d, actual %0d",
                           expected_totals[0], m_prime_total);
                    error_count++;
                    void'(expected_totals.pop_front());
                end else begin
                    void'(expected_totals.pop_front());
                end
            end
            // One long hold-off lets the block fill up and stall its input.
            if (!hold_done && results_seen == HOLD_AT_RESULT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("prime_sum_sieve test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly small limits keep the run short; a few reach the full range.
    task automatic queue_random_limits(input int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                pending_limits.push_back(LIMIT_W'($urandom_range(63)));
            end else if (sel < 90) begin
                pending_limits.push_back(LIMIT_W'($urandom_range(511, 64)));
            end else if (sel < 97) begin
                pending_limits.push_back(LIMIT_W'($urandom_range(1500, 512)));
            end else begin
                pending_limits.push_back(LIMIT_W'($urandom_range(4095)));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_limits.size() != 0 || s_valid || expected_totals.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int directed[$];
        directed = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 10, 11, 12, 13, 25, 49, 97, 100, 121,
                     255, 256, 1023, 1024, 2048, 4094, 4095};
        foreach (directed[i]) begin
            pending_limits.push_back(LIMIT_W'(directed[i]));
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        queue_random_limits(25);
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 11;
        queue_random_limits(30);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_limits(30);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("prime_sum_sieve test passed");
        end else begin
            $display("prime_sum_sieve test failed");
        end
        $finish;
    end

endmodule
